>>> sv/mcbd_pkg.sv
package mcbd_pkg;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_POLL     = 2'd0,
    KIND_RESTAMP  = 2'd1,
    KIND_SOFTWARE = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  localparam int unsigned DEFAULT_SETTLE_MS   = 30;
  localparam int unsigned US_PER_MS           = 1000;
  // 65535 ms * 1000 fits in 26 bits
  localparam int unsigned HOLD_W              = 26;
  localparam int unsigned CFG_W               = 16;
  localparam int unsigned CFG_IDX_W           = 3;
  localparam int unsigned SRC_W               = 3;
  localparam int unsigned ACT_W               = 3;

  // Per-request strobes sent to every lane
  typedef struct packed {
    logic poll;
    logic restamp;
  } lane_req_t;

  // Tag loaded with a press mask into the event merger
  typedef struct packed {
    logic             load;
    logic [SRC_W-1:0] src;
    logic             sw;
  } evt_tag_t;

endpackage

>>> sv/mcbd_lane.sv
module mcbd_lane
  import mcbd_pkg::*;
#(
  parameter int SOURCES   = 8,
  parameter int TIME_BITS = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lane_req_t                              req,
  input  logic [(SOURCES > 1 ? $clog2(SOURCES) : 1)-1:0] src_idx,
  input  logic                                   raw_bit,
  input  logic [TIME_BITS-1:0]                   now,
  input  logic [HOLD_W-1:0]                      hold,
  output logic                                   press
);

  logic [TIME_BITS-1:0] stamp_r [SOURCES];
  logic [SOURCES-1:0]   stamp_vld_r;
  logic [SOURCES-1:0]   samp_r;
  logic [SOURCES-1:0]   stab_r;

  logic [TIME_BITS-1:0] stamp_old;
  logic [TIME_BITS-1:0] stamp_cur;
  logic [TIME_BITS-1:0] age;
  logic                 changed;
  logic                 ripe;

  // Age of this source's bit, with a fresh stamp when the raw level moved
  always_comb begin
    stamp_old = stamp_vld_r[src_idx] ? stamp_r[src_idx] : '0;
    changed   = raw_bit ^ samp_r[src_idx];
    stamp_cur = changed ? now : stamp_old;
    age       = now - stamp_cur;
    ripe      = (raw_bit != stab_r[src_idx]) &&
                (age >= TIME_BITS'(hold));
    press     = req.poll && ripe && raw_bit;
  end

  // Timestamps: payload only, validity tracked separately
  always_ff @(posedge clk) begin
    if (req.restamp || (req.poll && changed)) begin
      stamp_r[src_idx] <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_vld_r <= '0;
      samp_r      <= '0;
      stab_r      <= '0;
    end else begin
      if (req.restamp || (req.poll && changed)) begin
        stamp_vld_r[src_idx] <= 1'b1;
      end
      if (req.poll) begin
        samp_r[src_idx] <= raw_bit;
        if (ripe) begin
          stab_r[src_idx] <= raw_bit;
        end
      end
    end
  end

endmodule

>>> sv/mcbd_merge.sv
module mcbd_merge
  import mcbd_pkg::*;
#(
  parameter int ACTIONS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  evt_tag_t           tag,
  input  logic [ACTIONS-1:0] mask,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ACT_W-1:0]   out_event_action,
  output logic [SRC_W-1:0]   out_event_source,
  output logic               out_from_software,
  output logic               out_last_event
);

  localparam int AW = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;

  logic [ACTIONS-1:0] pend_r, pend_nxt;
  logic [SRC_W-1:0]   src_r;
  logic               sw_r;
  logic               out_valid_r;
  logic [ACT_W-1:0]   act_r;
  logic [SRC_W-1:0]   osrc_r;
  logic               osw_r;
  logic               last_r;

  logic [ACTIONS-1:0] lowest;
  logic [ACTIONS-1:0] rest;
  logic [AW-1:0]      low_idx;
  logic               pop;
  logic               is_last;

  // Lowest pending action goes out first
  always_comb begin
    lowest  = pend_r & (~pend_r + ACTIONS'(1));
    rest    = pend_r & ~lowest;
    is_last = (rest == '0);
    low_idx = '0;
    for (int a = 0; a < ACTIONS; a++) begin
      if (lowest[a]) begin
        low_idx = AW'(a);
      end
    end
    pop   = (pend_r != '0) && (!out_valid_r || !out_stall);
    ready = (pend_r == '0) || (pop && is_last);
  end

  always_comb begin
    pend_nxt = pend_r;
    if (pop) begin
      pend_nxt = rest;
    end
    if (tag.load) begin
      pend_nxt = mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (tag.load) begin
      src_r <= tag.src;
      sw_r  <= tag.sw;
    end
    if (pop) begin
      act_r  <= ACT_W'(low_idx);
      osrc_r <= src_r;
      osw_r  <= sw_r;
      last_r <= is_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_action  = act_r;
  assign out_event_source  = osrc_r;
  assign out_from_software = osw_r;
  assign out_last_event    = last_r;

endmodule

>>> sv/multi_channel_button_debouncer.sv
// Channel   Direction  Handshake          Payload
// in        request    in_valid/in_stall  kind, source_index, raw_mask, action_index, now_us
// out       event      out_valid/out_stall event_action, event_source, from_software, last_event
// cfg       write      cfg_we             cfg_index, cfg_data (debounce ms per source)
//
// A request is evaluated in the cycle it is accepted; all lanes update together.
// Its n press events leave the merger one per cycle while out_stall is low and keep it busy;
// the next request is taken in the cycle the last event moves to the output register.
// Reset is synchronous; it clears valid, sample, stable and pending bits and loads default
// hold times only. out_stall holds the output register; pending events then keep in_stall high.
module multi_channel_button_debouncer
  import mcbd_pkg::*;
#(
  parameter int SOURCES   = 8,
  parameter int ACTIONS   = 8,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [SRC_W-1:0]     in_source_index,
  input  logic [7:0]           in_raw_mask,
  input  logic [7:0]           in_action_index,
  input  logic [TIME_BITS-1:0] in_now_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ACT_W-1:0]     out_event_action,
  output logic [SRC_W-1:0]     out_event_source,
  output logic                 out_from_software,
  output logic                 out_last_event,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  logic [HOLD_W-1:0]  hold_r [SOURCES];
  logic [HOLD_W-1:0]  hold_nxt;
  logic [HOLD_W-1:0]  hold_sel;
  logic [SW-1:0]      src_idx;
  logic [SW-1:0]      cfg_idx;
  logic               src_ok;
  logic               accept;
  logic               ready;
  kind_t              kind;
  lane_req_t          req;
  evt_tag_t           tag;
  logic [ACTIONS-1:0] press;
  logic [ACTIONS-1:0] sw_mask;
  logic               sw_evt;

  // Hold time in us per source, worked out at write time
  always_comb begin
    cfg_idx  = SW'(cfg_index);
    hold_nxt = (cfg_data == '0) ? HOLD_W'(DEFAULT_SETTLE_MS * US_PER_MS)
                                : HOLD_W'(cfg_data) * HOLD_W'(US_PER_MS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SOURCES; s++) begin
        hold_r[s] <= HOLD_W'(DEFAULT_SETTLE_MS * US_PER_MS);
      end
    end else if (cfg_we && (32'(cfg_index) < SOURCES)) begin
      hold_r[cfg_idx] <= hold_nxt;
    end
  end

  // Request decode
  always_comb begin
    kind     = kind_t'(in_kind);
    accept   = in_valid && ready;
    in_stall = !ready;
    src_idx  = SW'(in_source_index);
    src_ok   = 32'(in_source_index) < SOURCES;
    hold_sel = hold_r[src_idx];
    req.poll    = accept && src_ok && (kind == KIND_POLL);
    req.restamp = accept && src_ok && (kind == KIND_RESTAMP);
    for (int a = 0; a < ACTIONS; a++) begin
      sw_mask[a] = (in_action_index == 8'(a));
    end
    sw_evt   = accept && (kind == KIND_SOFTWARE) && (sw_mask != '0);
    tag.load = sw_evt || (req.poll && (press != '0));
    tag.src  = sw_evt ? '0 : in_source_index;
    tag.sw   = sw_evt;
  end

  // One lane per action bit
  for (genvar a = 0; a < ACTIONS; a++) begin : g_lane
    logic raw_bit;
    if (a < 8) begin : g_raw
      assign raw_bit = in_raw_mask[a];
    end else begin : g_zero
      assign raw_bit = 1'b0;
    end

    mcbd_lane #(
      .SOURCES   (SOURCES),
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req),
      .src_idx (src_idx),
      .raw_bit (raw_bit),
      .now     (in_now_us),
      .hold    (hold_sel),
      .press   (press[a])
    );
  end

  // Presses and software events merged into an ordered event stream
  mcbd_merge #(
    .ACTIONS (ACTIONS)
  ) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .tag               (tag),
    .mask              (sw_evt ? sw_mask : press),
    .ready             (ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_action  (out_event_action),
    .out_event_source  (out_event_source),
    .out_from_software (out_from_software),
    .out_last_event    (out_last_event)
  );

endmodule
